>>> sv/cubic_curve_point_and_derivatives_unit_assert.svh
// Assertion macros shared by the curve unit.
`ifndef CUBIC_CURVE_POINT_AND_DERIVATIVES_UNIT_ASSERT_SVH
`define CUBIC_CURVE_POINT_AND_DERIVATIVES_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define CCPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ccpd assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define CCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
		else $error("ccpd assertion failed");
`else
`define CCPD_ASSERT(lbl, clk, rst_n, prop)
`define CCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/ccpd_pkg.sv
package ccpd_pkg;

	// Fixed result formats.
	localparam int OUT_W   = 40;
	localparam int RAD_W   = 48;
	localparam int HALF_W  = OUT_W / 2;
	localparam int SQ_W    = 2 * OUT_W;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int NUM_W   = SQ_W + ROOT_W;
	localparam int QUO_W   = RAD_W;
	localparam int CMP_W   = SQ_W + QUO_W;
	localparam int T_IN_W  = 17;
	localparam int NUM_REGS = 8;

	// Operation selector codes.
	localparam logic [1:0] OP_POINT  = 2'd0;
	localparam logic [1:0] OP_D1     = 2'd1;
	localparam logic [1:0] OP_D2     = 2'd2;
	localparam logic [1:0] OP_RADIUS = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// Per-item side data that rides alongside the radius pipeline.
	typedef struct packed {
		logic [1:0]              op;
		logic signed [OUT_W-1:0] ox;
		logic signed [OUT_W-1:0] oy;
		logic                    sat;
	} carry_t;

	typedef struct packed {
		carry_t          side;
		logic            zero;
		logic            neg;
		logic [SQ_W-1:0] den;
	} tail_t;

	typedef struct packed {
		tail_t                   tail;
		logic signed [RAD_W-1:0] rad;
		logic                    rad_sat;
	} res_t;

endpackage

>>> sv/ccpd_radius.sv
`include "cubic_curve_point_and_derivatives_unit_assert.svh"

module ccpd_radius (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic signed [ccpd_pkg::OUT_W-1:0] px,
	input  logic signed [ccpd_pkg::OUT_W-1:0] py,
	input  logic signed [ccpd_pkg::OUT_W-1:0] qx,
	input  logic signed [ccpd_pkg::OUT_W-1:0] qy,
	input  ccpd_pkg::carry_t                side_in,
	output logic                            out_valid,
	output ccpd_pkg::res_t                  res
);

	localparam int OUT_W  = ccpd_pkg::OUT_W;
	localparam int HW     = ccpd_pkg::HALF_W;
	localparam int SQ_W   = ccpd_pkg::SQ_W;
	localparam int ROOT_W = ccpd_pkg::ROOT_W;
	localparam int REM_W  = ccpd_pkg::REM_W;
	localparam int NUM_W  = ccpd_pkg::NUM_W;
	localparam int QUO_W  = ccpd_pkg::QUO_W;
	localparam int CMP_W  = ccpd_pkg::CMP_W;
	localparam int RAD_W  = ccpd_pkg::RAD_W;
	localparam int PP_W   = OUT_W + HW + 1;

	// Operand pairs: px*px, py*py, px*qy, py*qx.
	logic signed [OUT_W-1:0] fa [4];
	logic signed [OUT_W-1:0] fb [4];

	always_comb begin
		fa[0] = px; fb[0] = px;
		fa[1] = py; fb[1] = py;
		fa[2] = px; fb[2] = qy;
		fa[3] = py; fb[3] = qx;
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [PP_W-1:0] pl_s1 [4];
	logic signed [PP_W-1:0] ph_s1 [4];
	logic signed [SQ_W-1:0] prod_s2 [4];
	logic [SQ_W-1:0] s_s3;
	logic signed [SQ_W:0] cross_s3;
	logic [SQ_W-1:0] s_s4;
	ccpd_pkg::tail_t tail_s4;
	ccpd_pkg::carry_t side_s1, side_s2, side_s3;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Products split into a low and a high half of the second operand, then
	// recombined; then the squared length and the cross product.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				pl_s1[k] <= PP_W'(fa[k]) * PP_W'($signed({1'b0, fb[k][HW-1:0]}));
				ph_s1[k] <= PP_W'(fa[k]) * PP_W'($signed(fb[k][OUT_W-1:HW]));
				prod_s2[k] <= (SQ_W'(ph_s1[k]) <<< HW) + SQ_W'(pl_s1[k]);
			end
			side_s1 <= side_in;
			side_s2 <= side_s1;
			s_s3 <= SQ_W'(prod_s2[0]) + SQ_W'(prod_s2[1]);
			cross_s3 <= (SQ_W+1)'(prod_s2[2]) - (SQ_W+1)'(prod_s2[3]);
			side_s3 <= side_s2;
			s_s4 <= s_s3;
			tail_s4.side <= side_s3;
			tail_s4.zero <= (cross_s3 == '0);
			tail_s4.neg  <= cross_s3[SQ_W];
			tail_s4.den  <= cross_s3[SQ_W] ? SQ_W'(-cross_s3) : SQ_W'(cross_s3);
		end
	end

	// Square root, one result bit per stage.
	logic                  v_sq    [ROOT_W];
	logic [ROOT_W-1:0]     root_sq [ROOT_W];
	logic [REM_W-1:0]      rem_sq  [ROOT_W];
	logic [SQ_W-1:0]       s_sq    [ROOT_W];
	ccpd_pkg::tail_t       tail_sq [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		logic              pv;
		logic [ROOT_W-1:0] proot;
		logic [REM_W-1:0]  prem, rem_in, trial;
		logic [SQ_W-1:0]   ps;
		ccpd_pkg::tail_t   ptail;
		logic              take;

		if (i == 0) begin : g_first
			assign pv = v_s4;
			assign proot = '0;
			assign prem = '0;
			assign ps = s_s4;
			assign ptail = tail_s4;
		end else begin : g_next
			assign pv = v_sq[i-1];
			assign proot = root_sq[i-1];
			assign prem = rem_sq[i-1];
			assign ps = s_sq[i-1];
			assign ptail = tail_sq[i-1];
		end

		assign rem_in = {prem[REM_W-3:0], ps[SQ_W-1-2*i -: 2]};
		assign trial = REM_W'({proot, 2'b01});
		assign take = (rem_in >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[i] <= 1'b0;
			end else if (adv) begin
				v_sq[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sq[i] <= take ? rem_in - trial : rem_in;
				root_sq[i] <= {proot[ROOT_W-2:0], take};
				s_sq[i] <= ps;
				tail_sq[i] <= ptail;
			end
		end
	end

	// Numerator s * sqrt(s) from products of 20-bit pieces; stage numbers here
	// continue after the square-root stages.
	logic [2*HW-1:0] pm_s5 [8];
	logic [NUM_W-1:0] lo_s6, hi_s6, num_s7, num_s8;
	logic ovf_s8;
	ccpd_pkg::tail_t tail_s5, tail_s6, tail_s7, tail_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_sq[ROOT_W-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 2; j++) begin
					pm_s5[2*i+j] <= (2*HW)'(s_sq[ROOT_W-1][HW*i +: HW]) *
						(2*HW)'(root_sq[ROOT_W-1][HW*j +: HW]);
				end
			end
			tail_s5 <= tail_sq[ROOT_W-1];
			lo_s6 <= NUM_W'(pm_s5[0]) + (NUM_W'(pm_s5[2]) << HW) +
				(NUM_W'(pm_s5[4]) << (2*HW)) + (NUM_W'(pm_s5[6]) << (3*HW));
			hi_s6 <= NUM_W'(pm_s5[1]) + (NUM_W'(pm_s5[3]) << HW) +
				(NUM_W'(pm_s5[5]) << (2*HW)) + (NUM_W'(pm_s5[7]) << (3*HW));
			tail_s6 <= tail_s5;
			num_s7 <= lo_s6 + (hi_s6 << HW);
			tail_s7 <= tail_s6;
			num_s8 <= num_s7;
			ovf_s8 <= (CMP_W'(num_s7) >= {tail_s7.den, QUO_W'(0)});
			tail_s8 <= tail_s7;
		end
	end

	// Restoring division, one quotient bit per stage; the quotient is known
	// to fit unless the overflow flag is set.
	logic              v_dv    [QUO_W];
	logic [SQ_W-1:0]   rem_dv  [QUO_W];
	logic [QUO_W-1:0]  q_dv    [QUO_W];
	logic [QUO_W-1:0]  nlo_dv  [QUO_W];
	logic              ovf_dv  [QUO_W];
	ccpd_pkg::tail_t   tail_dv [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		logic             pv, povf, ge;
		logic [SQ_W-1:0]  prem;
		logic [QUO_W-1:0] pq, pnlo;
		logic [SQ_W:0]    rem2;
		ccpd_pkg::tail_t  ptail;

		if (j == 0) begin : g_first
			assign pv = v_s8;
			assign prem = SQ_W'(num_s8[NUM_W-1:QUO_W]);
			assign pq = '0;
			assign pnlo = num_s8[QUO_W-1:0];
			assign povf = ovf_s8;
			assign ptail = tail_s8;
		end else begin : g_next
			assign pv = v_dv[j-1];
			assign prem = rem_dv[j-1];
			assign pq = q_dv[j-1];
			assign pnlo = nlo_dv[j-1];
			assign povf = ovf_dv[j-1];
			assign ptail = tail_dv[j-1];
		end

		assign rem2 = {prem, pnlo[QUO_W-1-j]};
		assign ge = (rem2 >= {1'b0, ptail.den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv[j] <= 1'b0;
			end else if (adv) begin
				v_dv[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_dv[j] <= ge ? SQ_W'(rem2 - {1'b0, ptail.den}) : rem2[SQ_W-1:0];
				q_dv[j] <= {pq[QUO_W-2:0], ge};
				nlo_dv[j] <= pnlo;
				ovf_dv[j] <= povf;
				tail_dv[j] <= ptail;
			end
		end
	end

	// Apply the sign and saturate to the radius width.
	logic [QUO_W-1:0] qm;

	assign qm = q_dv[QUO_W-1];
	assign out_valid = v_dv[QUO_W-1];

	always_comb begin
		res.tail = tail_dv[QUO_W-1];
		res.rad_sat = 1'b0;
		res.rad = $signed(RAD_W'(qm));
		if (ovf_dv[QUO_W-1]) begin
			res.rad_sat = 1'b1;
			res.rad = res.tail.neg ? {1'b1, {(RAD_W-1){1'b0}}} : {1'b0, {(RAD_W-1){1'b1}}};
		end else if (!res.tail.neg) begin
			if (qm[QUO_W-1]) begin
				res.rad_sat = 1'b1;
				res.rad = {1'b0, {(RAD_W-1){1'b1}}};
			end
		end else begin
			if (qm[QUO_W-1] && (|qm[QUO_W-2:0])) begin
				res.rad_sat = 1'b1;
				res.rad = {1'b1, {(RAD_W-1){1'b0}}};
			end else begin
				res.rad = $signed(RAD_W'(-qm));
			end
		end
	end

	// A zero cross product must set the zero flag carried in the tail.
	`CCPD_ASSERT_NEXT(a_zero_follows, clk, arst_n, adv && v_s3 && (cross_s3 == '0), tail_s4.zero)

endmodule

>>> sv/cubic_curve_point_and_derivatives_unit.sv
// Cubic curve evaluator. Eight coordinate registers (start, two interior
// coefficients, finish; x then y, signed Q.16) are written through the cfg
// port; the user must write them only while the unit is idle, as the block
// does not enforce it. Each input transfer carries a parameter t (unsigned,
// T_FRAC_BITS fraction bits, clamped to one) and an operation: point, first
// derivative, second derivative or radius of curvature. Every input produces
// exactly one result, and a new item is taken every cycle while the output
// side accepts. The pipeline length is set by the radius path: a square root
// of 40 stages (one root bit each) and a divider of 48 stages (one quotient
// bit each); all operations travel the same pipeline so results leave in
// order. The whole pipeline holds while a result waits on m_tready.
`include "cubic_curve_point_and_derivatives_unit_assert.svh"

module cubic_curve_point_and_derivatives_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [23:0]            s_tdata,   // [16:0] t_value, [23:17] zero
	input  logic [1:0]             s_tuser,   // [1:0] operation
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [127:0]           m_tdata,   // [39:0] out_x, [79:40] out_y, [127:80] radius
	output logic [1:0]             m_tuser,   // [1:0] status
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	localparam int F      = T_FRAC_BITS;
	localparam int CW     = COORD_WIDTH;
	localparam int OUT_W  = ccpd_pkg::OUT_W;
	localparam int RAD_W  = ccpd_pkg::RAD_W;
	localparam int T_IN_W = ccpd_pkg::T_IN_W;
	localparam int TW     = F + 1;
	localparam int TIW    = (TW > T_IN_W) ? TW : T_IN_W;
	localparam int SQW    = 2 * TW;
	localparam int CUW    = 3 * TW;
	localparam int WW     = 2 * F + 3;
	localparam int W2W    = F + 4;
	localparam int PAW    = CW + WW;
	localparam int PBW    = CW + W2W;
	localparam int ACC_W  = PAW + 2;
	localparam int EXT_W  = (ACC_W + 1 > OUT_W + 1) ? ACC_W + 1 : OUT_W + 1;
	localparam logic [TW-1:0] ONE_T = {1'b1, {F{1'b0}}};
	localparam logic [CUW-1:0] HALF_CU = CUW'(1) << (F - 1);
	localparam logic signed [EXT_W-1:0] RND_A = EXT_W'(1) << (2 * F - 1);
	localparam logic signed [EXT_W-1:0] RND_B = EXT_W'(1) << (F - 1);

	logic adv;

	// The pipeline moves whenever the output register is free or drained.
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Coordinate registers; writes beyond the list are dropped.
	logic signed [CW-1:0] coord_q [ccpd_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ccpd_pkg::NUM_REGS; k++) begin
				coord_q[k] <= '0;
			end
		end else if (cfg_we && (cfg_index < 4'(ccpd_pkg::NUM_REGS))) begin
			coord_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Clamp t to one.
	logic [TIW-1:0] t_in;
	logic [TW-1:0]  t_clamp;

	assign t_in = TIW'(s_tdata[T_IN_W-1:0]);
	assign t_clamp = (t_in > TIW'(ONE_T)) ? ONE_T : TW'(t_in);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [1:0] op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7, op_s8;
	logic [TW-1:0] t_s1, r_s1, t_s2, r_s2;
	logic [SQW-1:0] rr_s2, tt_s2, rt_s2;
	logic signed [W2W-1:0] w2_s2 [4];
	logic signed [W2W-1:0] w2_s3 [4];
	logic signed [W2W-1:0] w2_s4 [4];
	logic [CUW-1:0] cu_s3 [4];
	logic signed [WW-1:0] w1_s3 [4];
	logic signed [WW-1:0] wa_s4 [4];
	logic signed [PAW-1:0] pax_s5 [4];
	logic signed [PAW-1:0] pay_s5 [4];
	logic signed [PBW-1:0] pbx_s5 [4];
	logic signed [PBW-1:0] pby_s5 [4];
	logic signed [ACC_W-1:0] sax_s6 [2];
	logic signed [ACC_W-1:0] say_s6 [2];
	logic signed [ACC_W-1:0] sbx_s6 [2];
	logic signed [ACC_W-1:0] sby_s6 [2];
	logic signed [EXT_W-1:0] ax_s7, ay_s7, bx_s7, by_s7;
	logic signed [OUT_W-1:0] ax_s8, ay_s8, bx_s8, by_s8;
	logic sat_a_s8, sat_b_s8;

	// Valid bits of the weight and combination stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Second derivative weights, linear in r and t.
	logic signed [W2W-1:0] r_e, t_e;
	logic signed [W2W-1:0] w2_n [4];

	always_comb begin
		r_e = $signed(W2W'(r_s1));
		t_e = $signed(W2W'(t_s1));
		w2_n[0] = (r_e <<< 2) + (r_e <<< 1);
		w2_n[1] = (t_e <<< 1) - (r_e <<< 2);
		w2_n[2] = (r_e <<< 1) - (t_e <<< 2);
		w2_n[3] = (t_e <<< 2) + (t_e <<< 1);
	end

	// First derivative weights from the squares.
	logic signed [WW-1:0] rr_e, tt_e, rt_e;
	logic signed [WW-1:0] w1_n [4];

	always_comb begin
		rr_e = $signed(WW'(rr_s2));
		tt_e = $signed(WW'(tt_s2));
		rt_e = $signed(WW'(rt_s2));
		w1_n[0] = -((rr_e <<< 1) + rr_e);
		w1_n[1] = rr_e - (rt_e <<< 1);
		w1_n[2] = (rt_e <<< 1) - tt_e;
		w1_n[3] = (tt_e <<< 1) + tt_e;
	end

	// Point weights: cubes rounded to 2F fraction bits.
	logic [CUW-1:0] cu_rnd [4];
	logic signed [WW-1:0] wa_n [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cu_rnd[k] = cu_s3[k] + HALF_CU;
			wa_n[k] = (op_s3 == ccpd_pkg::OP_POINT) ? $signed(WW'(cu_rnd[k] >> F)) : w1_s3[k];
		end
	end

	// Weighted sums with round half up.
	logic signed [EXT_W-1:0] sum_ax, sum_ay, sum_bx, sum_by;

	always_comb begin
		sum_ax = EXT_W'(sax_s6[0]) + EXT_W'(sax_s6[1]) + RND_A;
		sum_ay = EXT_W'(say_s6[0]) + EXT_W'(say_s6[1]) + RND_A;
		sum_bx = EXT_W'(sbx_s6[0]) + EXT_W'(sbx_s6[1]) + RND_B;
		sum_by = EXT_W'(sby_s6[0]) + EXT_W'(sby_s6[1]) + RND_B;
	end

	function automatic logic sat_flag(input logic signed [EXT_W-1:0] v);
		logic [EXT_W-OUT_W:0] hi;
		hi = v[EXT_W-1:OUT_W-1];
		return !((&hi) || !(|hi));
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_val(input logic signed [EXT_W-1:0] v);
		if (!sat_flag(v)) begin
			return v[OUT_W-1:0];
		end else if (v[EXT_W-1]) begin
			return {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction

	// Payload of the weight and combination stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= s_tuser;
			t_s1 <= t_clamp;
			r_s1 <= ONE_T - t_clamp;

			op_s2 <= op_s1;
			t_s2 <= t_s1;
			r_s2 <= r_s1;
			rr_s2 <= SQW'(r_s1) * SQW'(r_s1);
			tt_s2 <= SQW'(t_s1) * SQW'(t_s1);
			rt_s2 <= SQW'(r_s1) * SQW'(t_s1);
			w2_s2 <= w2_n;

			op_s3 <= op_s2;
			cu_s3[0] <= CUW'(rr_s2) * CUW'(r_s2);
			cu_s3[1] <= CUW'(rr_s2) * CUW'(t_s2);
			cu_s3[2] <= CUW'(tt_s2) * CUW'(r_s2);
			cu_s3[3] <= CUW'(tt_s2) * CUW'(t_s2);
			w1_s3 <= w1_n;
			w2_s3 <= w2_s2;

			op_s4 <= op_s3;
			wa_s4 <= wa_n;
			w2_s4 <= w2_s3;

			op_s5 <= op_s4;
			for (int k = 0; k < 4; k++) begin
				pax_s5[k] <= PAW'(coord_q[2*k]) * PAW'(wa_s4[k]);
				pay_s5[k] <= PAW'(coord_q[2*k+1]) * PAW'(wa_s4[k]);
				pbx_s5[k] <= PBW'(coord_q[2*k]) * PBW'(w2_s4[k]);
				pby_s5[k] <= PBW'(coord_q[2*k+1]) * PBW'(w2_s4[k]);
			end

			op_s6 <= op_s5;
			for (int k = 0; k < 2; k++) begin
				sax_s6[k] <= ACC_W'(pax_s5[2*k]) + ACC_W'(pax_s5[2*k+1]);
				say_s6[k] <= ACC_W'(pay_s5[2*k]) + ACC_W'(pay_s5[2*k+1]);
				sbx_s6[k] <= ACC_W'(pbx_s5[2*k]) + ACC_W'(pbx_s5[2*k+1]);
				sby_s6[k] <= ACC_W'(pby_s5[2*k]) + ACC_W'(pby_s5[2*k+1]);
			end

			op_s7 <= op_s6;
			ax_s7 <= sum_ax >>> (2 * F);
			ay_s7 <= sum_ay >>> (2 * F);
			bx_s7 <= sum_bx >>> F;
			by_s7 <= sum_by >>> F;

			op_s8 <= op_s7;
			ax_s8 <= sat_val(ax_s7);
			ay_s8 <= sat_val(ay_s7);
			bx_s8 <= sat_val(bx_s7);
			by_s8 <= sat_val(by_s7);
			sat_a_s8 <= sat_flag(ax_s7) || sat_flag(ay_s7);
			sat_b_s8 <= sat_flag(bx_s7) || sat_flag(by_s7);
		end
	end

	// Pick the point or derivative result that the operation asks for; a radius item carries zero coordinates.
	ccpd_pkg::carry_t side_s8;

	always_comb begin
		side_s8.op = op_s8;
		unique case (op_s8)
			ccpd_pkg::OP_POINT, ccpd_pkg::OP_D1: begin
				side_s8.ox = ax_s8;
				side_s8.oy = ay_s8;
				side_s8.sat = sat_a_s8;
			end
			ccpd_pkg::OP_D2: begin
				side_s8.ox = bx_s8;
				side_s8.oy = by_s8;
				side_s8.sat = sat_b_s8;
			end
			ccpd_pkg::OP_RADIUS: begin
				side_s8.ox = '0;
				side_s8.oy = '0;
				side_s8.sat = sat_a_s8 || sat_b_s8;
			end
			default: begin
				side_s8.ox = '0;
				side_s8.oy = '0;
				side_s8.sat = 1'b0;
			end
		endcase
	end

	logic res_valid;
	ccpd_pkg::res_t res;

	ccpd_radius u_radius (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s8),
		.px        (ax_s8),
		.py        (ay_s8),
		.qx        (bx_s8),
		.qy        (by_s8),
		.side_in   (side_s8),
		.out_valid (res_valid),
		.res       (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (res.tail.side.op == ccpd_pkg::OP_RADIUS) begin
				if (res.tail.zero) begin
					m_tdata <= '0;
					m_tuser <= ccpd_pkg::ST_ZERO;
				end else begin
					m_tdata <= {res.rad, {(2*OUT_W){1'b0}}};
					m_tuser <= (res.tail.side.sat || res.rad_sat) ?
						ccpd_pkg::ST_SAT : ccpd_pkg::ST_OK;
				end
			end else begin
				m_tdata <= {{RAD_W{1'b0}}, res.tail.side.oy, res.tail.side.ox};
				m_tuser <= res.tail.side.sat ? ccpd_pkg::ST_SAT : ccpd_pkg::ST_OK;
			end
		end
	end

	`CCPD_ASSERT(a_zero_clears, clk, arst_n, m_tvalid && (m_tuser == ccpd_pkg::ST_ZERO) |-> (m_tdata == '0))
	`CCPD_ASSERT_NEXT(a_stall_keeps_s1, clk, arst_n, !s_tready && v_s1, v_s1)
	`CCPD_ASSERT(a_s1_from_transfer, clk, arst_n, $rose(v_s1) |-> $past(s_tvalid && s_tready))

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

	// Register indexes of the coordinate file; anything from REG_BEYOND up is ignored.
	localparam logic [3:0] REG_START_X   = 4'd0;
	localparam logic [3:0] REG_START_Y   = 4'd1;
	localparam logic [3:0] REG_INNER1_X  = 4'd2;
	localparam logic [3:0] REG_INNER1_Y  = 4'd3;
	localparam logic [3:0] REG_INNER2_X  = 4'd4;
	localparam logic [3:0] REG_INNER2_Y  = 4'd5;
	localparam logic [3:0] REG_FINISH_X  = 4'd6;
	localparam logic [3:0] REG_FINISH_Y  = 4'd7;
	localparam logic [3:0] REG_BEYOND    = 4'd8;

	localparam int  T_ONE       = 65536;
	localparam int  PIPE_DRAIN  = 150;
	localparam int  STALL_LIMIT = 5000;
	localparam int  RAND_PHASES = 12;
	localparam int  PHASE_ITEMS = 100;

	typedef struct packed {
		logic signed [ccpd_pkg::OUT_W-1:0] x;
		logic signed [ccpd_pkg::OUT_W-1:0] y;
		logic signed [ccpd_pkg::RAD_W-1:0] rad;
		logic [1:0]                        st;
	} curve_res_t;

	typedef struct {
		logic [1:0]  op;
		logic [16:0] t;
		logic [1:0]  st_at_reset;
	} probe_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [127:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we;
	logic [3:0] cfg_index;
	logic [31:0] cfg_data;

	logic signed [31:0] coeff [8];
	curve_res_t expected_results [$];
	int mismatches;
	int idle_cycles;
	logic quiet;

	// Directed probes: every operation at both ends, the middle, and t above one.
	probe_row_t probes [16] = '{
		'{ccpd_pkg::OP_POINT,  17'd0,      ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D1,     17'd0,      ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D2,     17'd0,      ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_RADIUS, 17'd0,      ccpd_pkg::ST_ZERO},
		'{ccpd_pkg::OP_POINT,  17'd65536,  ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D1,     17'd65536,  ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D2,     17'd65536,  ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_RADIUS, 17'd65536,  ccpd_pkg::ST_ZERO},
		'{ccpd_pkg::OP_POINT,  17'd32768,  ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D1,     17'd32768,  ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D2,     17'd32768,  ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_RADIUS, 17'd32768,  ccpd_pkg::ST_ZERO},
		'{ccpd_pkg::OP_POINT,  17'd131071, ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D1,     17'd131071, ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_D2,     17'd131071, ccpd_pkg::ST_OK},
		'{ccpd_pkg::OP_RADIUS, 17'd65537,  ccpd_pkg::ST_ZERO}
	};

	cubic_curve_point_and_derivatives_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),    // [16:0] t_value, [23:17] zero
		.s_tuser(s_tuser),    // [1:0] operation
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),    // [39:0] out_x, [79:40] out_y, [127:80] radius
		.m_tuser(m_tuser),    // [1:0] status
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Round half up, then shift arithmetically.
	function automatic logic signed [127:0] round_shift(input logic signed [127:0] a, input int n);
		return (a + (128'sd1 <<< (n - 1))) >>> n;
	endfunction

	// Saturate to a signed width and note whether clipping happened.
	function automatic logic signed [127:0] clip(input logic signed [127:0] a, input int w,
			inout logic hit);
		logic signed [127:0] hi_lim;
		hi_lim = (128'sd1 <<< (w - 1)) - 128'sd1;
		if (a > hi_lim) begin
			hit = 1'b1;
			return hi_lim;
		end
		if (a < -hi_lim - 128'sd1) begin
			hit = 1'b1;
			return -hi_lim - 128'sd1;
		end
		return a;
	endfunction

	// Weighted sum of the four coefficients of one axis, rounded and saturated.
	function automatic logic signed [127:0] axis_sum(input logic signed [127:0] w [4],
			input int dim, input int n, inout logic hit);
		logic signed [127:0] acc;
		logic signed [127:0] c;
		acc = 0;
		for (int k = 0; k < 4; k++) begin
			c = coeff[2 * k + dim];
			acc = acc + c * w[k];
		end
		return clip(round_shift(acc, n), ccpd_pkg::OUT_W, hit);
	endfunction

	// Expected result of one item under the current coordinates.
	function automatic curve_res_t curve_value(input logic [1:0] op, input logic [16:0] t_in);
		logic signed [127:0] t, r, px, py, qx, qy, cp, qs;
		logic signed [127:0] w0 [4];
		logic signed [127:0] w1 [4];
		logic signed [127:0] w2 [4];
		logic [127:0] sq, num, den, quo, cc;
		logic [63:0] root, cand;
		logic hit;
		curve_res_t res;
		res = '0;
		hit = 1'b0;
		t = $signed({111'd0, t_in});
		if (t > T_ONE)
			t = T_ONE;
		r = T_ONE - t;
		w0[0] = round_shift(r * r * r, 16);
		w0[1] = round_shift(r * r * t, 16);
		w0[2] = round_shift(t * t * r, 16);
		w0[3] = round_shift(t * t * t, 16);
		w1[0] = -3 * r * r;
		w1[1] = r * r - 2 * r * t;
		w1[2] = 2 * r * t - t * t;
		w1[3] = 3 * t * t;
		w2[0] = 6 * r;
		w2[1] = 2 * t - 4 * r;
		w2[2] = 2 * r - 4 * t;
		w2[3] = 6 * t;
		case (op)
			ccpd_pkg::OP_POINT: begin
				res.x = axis_sum(w0, 0, 32, hit);
				res.y = axis_sum(w0, 1, 32, hit);
			end
			ccpd_pkg::OP_D1: begin
				res.x = axis_sum(w1, 0, 32, hit);
				res.y = axis_sum(w1, 1, 32, hit);
			end
			ccpd_pkg::OP_D2: begin
				res.x = axis_sum(w2, 0, 16, hit);
				res.y = axis_sum(w2, 1, 16, hit);
			end
			default: begin
				px = axis_sum(w1, 0, 32, hit);
				py = axis_sum(w1, 1, 32, hit);
				qx = axis_sum(w2, 0, 16, hit);
				qy = axis_sum(w2, 1, 16, hit);
				cp = px * qy - py * qx;
				// A straight stretch has no curvature: the denominator is zero.
				if (cp == 0) begin
					res.st = ccpd_pkg::ST_ZERO;
					return res;
				end
				sq = px * px + py * py;
				root = '0;
				for (int b = 63; b >= 0; b--) begin
					cand = root | (64'd1 << b);
					cc = {64'd0, cand} * {64'd0, cand};
					if (cc <= sq)
						root = cand;
				end
				num = sq * {64'd0, root};
				den = (cp < 0) ? -cp : cp;
				quo = num / den;
				qs = (cp < 0) ? -$signed(quo) : $signed(quo);
				res.rad = clip(qs, ccpd_pkg::RAD_W, hit);
			end
		endcase
		res.st = hit ? ccpd_pkg::ST_SAT : ccpd_pkg::ST_OK;
		return res;
	endfunction

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// One register write on the configuration port.
	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < REG_BEYOND)
			coeff[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drive one input transfer and record what it should produce.
	task automatic send_item(input logic [1:0] op, input logic [16:0] t, input logic fixed,
			input logic [1:0] fixed_st);
		int gap;
		curve_res_t want;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {7'd0, t};
		s_tuser <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (fixed) begin
			want = '0;
			want.st = fixed_st;
		end else begin
			want = curve_value(op, t);
		end
		expected_results.push_back(want);
		if ($urandom_range(0, 99) == 0)
			quiet = ~quiet;
	endtask

	// Wait until every result of the phase is back, with the input side idle.
	task automatic drain_phase();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Write all eight coordinates, and one ignored index beyond the list.
	task automatic load_coords(input logic signed [31:0] vals [8]);
		for (int k = 0; k < 8; k++)
			write_reg(k[3:0], vals[k]);
		write_reg(4'($urandom_range(REG_BEYOND, 15)), $urandom);
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return 32'h7fff_ffff;
			3: return 32'h8000_0000;
			4: return 32'd0;
			default: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
		endcase
	endfunction

	function automatic logic [16:0] random_t();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd65536;
			2, 3: return 17'($urandom);
			default: return 17'($urandom_range(0, T_ONE));
		endcase
	endfunction

	// Stimulus and phases.
	initial begin
		logic signed [31:0] vals [8];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		mismatches = 0;
		for (int k = 0; k < 8; k++)
			coeff[k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Coordinates straight out of reset: every result is zero.
		foreach (probes[i])
			send_item(probes[i].op, probes[i].t, 1'b1, probes[i].st_at_reset);
		drain_phase();

		// Extreme coordinates: all maximum, all minimum, then a mix chosen by index bits 0 and 2.
		for (int ph = 0; ph < 3; ph++) begin
			for (int k = 0; k < 8; k++)
				vals[k] = (ph == 0) ? 32'h7fff_ffff : (ph == 1) ? 32'h8000_0000 :
					(k[0] ^ k[2]) ? 32'h7fff_ffff : 32'h8000_0000;
			load_coords(vals);
			foreach (probes[i])
				send_item(probes[i].op, probes[i].t, 1'b0, ccpd_pkg::ST_OK);
			drain_phase();
		end

		// Random coordinates with random items.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			for (int k = 0; k < 8; k++)
				vals[k] = random_coord();
			load_coords(vals);
			repeat (PHASE_ITEMS)
				send_item(2'($urandom_range(0, 3)), random_t(), 1'b0, ccpd_pkg::ST_OK);
			drain_phase();
		end

		repeat (PIPE_DRAIN) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: random back-pressure and checking against the oldest expectation.
	initial begin
		int stall;
		curve_res_t got, want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.x = m_tdata[39:0];
			got.y = m_tdata[79:40];
			got.rad = m_tdata[127:80];
			got.st = m_tuser;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: x=%0d y=%0d radius=%0d status=%0d",
						got.x, got.y, got.rad, got.st);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: exp x=%0d y=%0d r=%0d st=%0d, ",
							"got x=%0d y=%0d r=%0d st=%0d"},
							want.x, want.y, want.rad, want.st,
							got.x, got.y, got.rad, got.st);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
